// ===== design/ppem_pkg.sv =====
// ----------------------------------------------------------------------------
// ppem_pkg: shared constants for the pulse power/energy meter
// Fixed field widths, window rule constants, configuration register codes and divider job kinds.
// ----------------------------------------------------------------------------
package ppem_pkg;

	// field widths
	localparam int PPK_W   = 20;   // meter constant
	localparam int K_W     = 26;   // widest scale constant (36,000,000)
	localparam int OUT_W   = 32;   // result fields
	localparam int IN_TIME_W = 32; // time field on the stream

	// window rule constants
	localparam logic [K_W-1:0] HOUR_MS        = K_W'(3600000);
	localparam logic [K_W-1:0] HOUR_MS_TENTHS = K_W'(36000000);
	localparam int             MANY_WINDOW_MS = 2000;
	localparam int             MANY_PULSES    = 10;

	// configuration register indexes
	localparam logic CFG_PPK        = 1'b0;
	localparam logic CFG_CALIBRATED = 1'b1;

	// divider job kinds
	localparam logic DIV_RATE   = 1'b0;
	localparam logic DIV_ENERGY = 1'b1;

endpackage

// ===== design/pulse_power_energy_meter.sv =====
// ----------------------------------------------------------------------------
// pulse_power_energy_meter: power and energy from an energy pulse pin
// Counts rising edges of the sampled pulse pin, estimates power in 0.1 W from
// a restartable counting window and reports energy as total / meter constant.
// ----------------------------------------------------------------------------
// Usage
//   s_*   : one request per tick, s_tdata = {time_ms, pin_level}.
//   m_*   : one result per request, m_tdata = {energy_kwh, power_tenth_watt}.
//   cfg_* : register writes (index 0 meter constant, index 1 calibrated);
//           cfg_ready is always high, write only while the meter is idle.
// Sequence
//   A request passes from acceptance to the result register through the two
//   products on the shared multiplier, a decision step, up to two 32-step
//   restoring divisions on the one shared divider (window power, then energy;
//   the steps are skipped when the quotient saturates), and the output step.
//   s_tready is high only while the sequencer is idle, so a new request is
//   accepted only after the previous one has left the output step.
// Reset
//   arst_n clears counters, window, power, configuration registers and the valid flags; the
//   first sample after reset never counts as an edge. There is no clearing pass.
// Stall
//   A result waits in the output register while m_tready is low; the next
//   request is accepted meanwhile and its result holds in the sequencer until
//   the output register is free.
// ----------------------------------------------------------------------------
module pulse_power_energy_meter
	import ppem_pkg::*;
#(
	parameter int TIME_WIDTH  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// stream in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,   // [0] pin_level, [32:1] time_ms, [39:33] zero
	// stream out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata,   // [31:0] power_tenth_watt, [63:32] energy_kwh
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [PPK_W-1:0]     cfg_data
);

	// derived widths
	localparam int MW  = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
	localparam int PRW = MW + K_W;               // multiplier product
	localparam int DW  = TIME_WIDTH + PPK_W;     // divisor
	localparam int NW  = COUNT_WIDTH + K_W;      // dividend
	localparam int HW  = NW - OUT_W;             // dividend bits above quotient
	localparam int XW  = (HW > DW) ? HW : DW;    // saturation compare width

	// sequencer codes
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MULD   = 4'd1;
	localparam logic [3:0] S_MULN   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_DLOAD  = 4'd4;
	localparam logic [3:0] S_DITER  = 4'd5;
	localparam logic [3:0] S_DDONE  = 4'd6;
	localparam logic [3:0] S_OUT    = 4'd7;

	logic [3:0]             state_q;

	// configuration
	logic [PPK_W-1:0]       ppk_q;
	logic                   cal_q;

	// meter state
	logic                   last_valid_q;
	logic                   last_level_q;
	logic [COUNT_WIDTH-1:0] wp_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [TIME_WIDTH-1:0]  start_q;
	logic [OUT_W-1:0]       power_q;

	// per-request working registers
	logic [TIME_WIDTH-1:0]  now_q;
	logic [TIME_WIDTH-1:0]  elapsed_q;
	logic [DW-1:0]          d_q;
	logic [NW-1:0]          n_q;
	logic                   many_q;
	logic                   kind_q;
	logic [OUT_W-1:0]       energy_q;

	// divider registers
	logic [DW-1:0]          rem_q;
	logic [OUT_W-1:0]       low_q;
	logic [4:0]             cnt_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_power_q;
	logic [OUT_W-1:0]       out_energy_q;

	// request fields
	logic                   in_level;
	logic [TIME_WIDTH-1:0]  in_now;
	logic                   in_edge;
	logic                   in_accept;

	assign in_level  = s_tdata[0];
	assign in_now    = TIME_WIDTH'(s_tdata[IN_TIME_W:1]);
	assign in_edge   = last_valid_q && !last_level_q && in_level;
	assign in_accept = s_tvalid && s_tready;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {out_energy_q, out_power_q};

	// shared multiplier
	logic [MW-1:0]          mul_a;
	logic [K_W-1:0]         mul_b;
	logic [PRW-1:0]         mul_p;

	always_comb begin
		if (state_q == S_MULD) begin
			mul_a = MW'(elapsed_q);
			mul_b = K_W'(ppk_q);
		end else begin
			mul_a = MW'(wp_q);
			mul_b = (wp_q >= COUNT_WIDTH'(MANY_PULSES)) ? HOUR_MS : HOUR_MS_TENTHS;
		end
	end

	assign mul_p = PRW'(mul_a) * PRW'(mul_b);

	// window rule terms
	logic                   no_clock;
	logic                   is_many;
	logic                   is_few;
	logic                   is_none;
	logic                   period_up;
	logic                   need_energy;
	logic [DW:0]            d_plus;

	assign d_plus      = {1'b0, d_q} + (DW+1)'(ppk_q);
	assign period_up   = d_plus > (DW+1)'(HOUR_MS);
	assign no_clock    = (start_q == '0) || (ppk_q == '0);
	assign is_many     = (wp_q >= COUNT_WIDTH'(MANY_PULSES))
	                     && (elapsed_q >= TIME_WIDTH'(MANY_WINDOW_MS));
	assign is_few      = (wp_q != '0) && (wp_q < COUNT_WIDTH'(MANY_PULSES)) && period_up;
	assign is_none     = (wp_q == '0) && period_up;
	assign need_energy = cal_q && (ppk_q != '0);

	// shared divider operands and step
	logic [NW-1:0]          div_num;
	logic [DW-1:0]          div_den;
	logic                   div_sat;
	logic [DW:0]            trial;
	logic [DW:0]            diff;
	logic                   trial_ge;

	always_comb begin
		if (kind_q == DIV_RATE) begin
			div_num = n_q;
			div_den = d_q;
		end else begin
			div_num = NW'(total_q);
			div_den = DW'(ppk_q);
		end
	end

	assign div_sat  = XW'(div_num[NW-1:OUT_W]) >= XW'(div_den);
	assign trial    = {rem_q, low_q[OUT_W-1]};
	assign trial_ge = trial >= {1'b0, div_den};
	assign diff     = trial - {1'b0, div_den};

	// times ten with saturation for the many-pulses rule
	logic [OUT_W+3:0]       p10;
	logic [OUT_W-1:0]       p10_sat;

	assign p10     = {1'b0, low_q, 3'b000} + {3'b000, low_q, 1'b0};
	assign p10_sat = (p10[OUT_W+3:OUT_W] != '0) ? '1 : p10[OUT_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppk_q <= '0;
			cal_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PPK:        ppk_q <= cfg_data;
				CFG_CALIBRATED: cal_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// sequencer and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_valid_q <= 1'b0;
			last_level_q <= 1'b0;
			wp_q         <= '0;
			total_q      <= '0;
			start_q      <= '0;
			power_q      <= '0;
			kind_q       <= DIV_RATE;
			many_q       <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// output register valid flag
			if (state_q == S_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// capture request, count the edge
					if (in_accept) begin
						last_valid_q <= 1'b1;
						last_level_q <= in_level;
						if (in_edge) begin
							wp_q    <= wp_q + COUNT_WIDTH'(1);
							total_q <= total_q + COUNT_WIDTH'(1);
						end
						state_q <= S_MULD;
					end
				end
				S_MULD: begin
					state_q <= S_MULN;
				end
				S_MULN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					// window rules in priority order
					priority if (no_clock) begin
						power_q <= '0;
					end else if (is_many || is_few) begin
						many_q <= is_many;
					end else if (is_none) begin
						power_q <= '0;
					end else begin
						// window still open, keep the last estimate
						power_q <= power_q;
					end
					if (no_clock || is_many || is_few || is_none) begin
						start_q <= now_q;
						wp_q    <= '0;
					end
					if (!no_clock && (is_many || is_few)) begin
						kind_q  <= DIV_RATE;
						state_q <= S_DLOAD;
					end else if (need_energy) begin
						kind_q  <= DIV_ENERGY;
						state_q <= S_DLOAD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DLOAD: begin
					cnt_q <= '0;
					if (div_sat) begin
						state_q <= S_DDONE;
					end else begin
						state_q <= S_DITER;
					end
				end
				S_DITER: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= S_DDONE;
					end
				end
				S_DDONE: begin
					if (kind_q == DIV_RATE) begin
						power_q <= many_q ? p10_sat : low_q;
						if (need_energy) begin
							kind_q  <= DIV_ENERGY;
							state_q <= S_DLOAD;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// wait for a free output register
					if (!out_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_q     <= in_now;
			elapsed_q <= in_now - start_q;
		end
		if (state_q == S_MULD) begin
			d_q <= DW'(mul_p);
		end
		if (state_q == S_MULN) begin
			n_q <= NW'(mul_p);
		end
		if (state_q == S_DECIDE) begin
			energy_q <= '0;
		end
		if (state_q == S_DLOAD) begin
			if (div_sat) begin
				low_q <= '1;
			end else begin
				rem_q <= DW'(div_num[NW-1:OUT_W]);
				low_q <= div_num[OUT_W-1:0];
			end
		end
		if (state_q == S_DITER) begin
			rem_q <= trial_ge ? diff[DW-1:0] : trial[DW-1:0];
			low_q <= {low_q[OUT_W-2:0], trial_ge};
		end
		if (state_q == S_DDONE && kind_q == DIV_ENERGY) begin
			energy_q <= low_q;
		end
		if (state_q == S_OUT && (!out_valid_q || m_tready)) begin
			out_power_q  <= power_q;
			out_energy_q <= energy_q;
		end
	end

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == S_MULD)
		else $error("accepted request did not start the sequencer");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DITER |-> rem_q < div_den)
		else $error("divider remainder not below divisor");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && (no_clock || is_many || is_few || is_none))
		|=> (wp_q == '0 && start_q == $past(now_q)))
		else $error("window restart did not clear the window");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output step");

endmodule
